### design/interrupt_dispatch_queue_defines.svh
// Assertion macros for the interrupt dispatch queue.
`ifndef INTERRUPT_DISPATCH_QUEUE_DEFINES_SVH
`define INTERRUPT_DISPATCH_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IDQ_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define IDQ_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

### design/idq_pkg.sv
// Shared constants, codes and types of the interrupt dispatch queue.
`default_nettype none

package idq_pkg;

    localparam int DEF_NUM_LINES   = 32;
    localparam int DEF_QUEUE_DEPTH = 8;
    localparam int DEF_NUM_CPUS    = 2;
    localparam int DEF_TAG_WIDTH   = 16;

    localparam int IRQ_W     = 5;
    localparam int TAG_W     = 16;
    localparam int KIND_W    = 2;
    localparam int LIMIT_W   = 4;
    localparam int MASK_W    = 32;
    localparam int CPU_SLOTS = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

    localparam logic [KIND_W-1:0] KIND_DELIVER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CALLBACK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESUME   = 2'd2;

    localparam logic CFG_IRQ_MASK    = 1'b0;
    localparam logic CFG_QUEUE_LIMIT = 1'b1;

    localparam logic [1:0] OP_DELIVER  = 2'd0;
    localparam logic [1:0] OP_IMM_IDLE = 2'd1;
    localparam logic [1:0] OP_ENQUEUE  = 2'd2;
    localparam logic [1:0] OP_COMPLETE = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic             cpu;
        logic [IRQ_W-1:0] line;
        logic             imm;
        logic [TAG_W-1:0] tag;
    } cmd_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic              cpu;
        logic [IRQ_W-1:0]  line;
        logic [TAG_W-1:0]  tag;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

### design/interrupt_dispatch_queue.sv
// Top level of the per-CPU interrupt dispatch queue.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------
//  request  | start, busy              | func, cpu, irq, immediate, tag
//  result   | out_valid (strobe)       | kind, out_cpu, out_irq, out_tag, last
//  config   | cfg_valid, cfg_ready     | cfg_index, cfg_data
//
// One request at a time: the first result follows accept through the command register, the
// command queue and the result register; busy drops in the cycle after the last result.
// A completion passes through ST_ADV, plus ST_ADV and ST_POP per queued entry taken (memory read).
// Dropped requests never raise busy; a queued one clears it once it leaves the command queue.
// Results cannot be stalled. Reset clears all control state; wait memory
// is not cleared.
`default_nettype none

module interrupt_dispatch_queue #(
    parameter int NUM_LINES   = idq_pkg::DEF_NUM_LINES,
    parameter int QUEUE_DEPTH = idq_pkg::DEF_QUEUE_DEPTH,
    parameter int NUM_CPUS    = idq_pkg::DEF_NUM_CPUS,
    parameter int TAG_WIDTH   = idq_pkg::DEF_TAG_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        func,
    input  logic                        cpu,
    input  logic [idq_pkg::IRQ_W-1:0]   irq,
    input  logic                        immediate,
    input  logic [idq_pkg::TAG_W-1:0]   tag,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [idq_pkg::MASK_W-1:0]  cfg_data,
    output logic                        out_valid,
    output logic [idq_pkg::KIND_W-1:0]  kind,
    output logic                        out_cpu,
    output logic [idq_pkg::IRQ_W-1:0]   out_irq,
    output logic [idq_pkg::TAG_W-1:0]   out_tag,
    output logic                        last
);
    import idq_pkg::*;

    `include "interrupt_dispatch_queue_defines.svh"

    localparam int EFF_LINES = (NUM_LINES < 32) ? NUM_LINES : 32;
    localparam int CNW       = $clog2(QUEUE_DEPTH + 1);

    logic                           front_valid;
    cmd_t                           front_cmd;
    logic                           fifo_empty;
    cmd_t                           fifo_head;
    logic                           back_pop;
    logic [EFF_LINES-1:0]           pending;
    logic [CPU_SLOTS-1:0]           cpu_busy;
    logic [CPU_SLOTS-1:0][CNW-1:0]  q_count;
    logic                           back_active;
    result_t                        result;

    idq_front #(
        .NUM_LINES   (NUM_LINES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_CPUS    (NUM_CPUS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .cpu       (cpu),
        .irq       (irq),
        .immediate (immediate),
        .tag       (tag),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .cpu_busy  (cpu_busy),
        .q_count   (q_count),
        .cmd_valid (front_valid),
        .cmd       (front_cmd)
    );

    idq_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_valid),
        .push_cmd (front_cmd),
        .pop      (back_pop),
        .empty    (fifo_empty),
        .head_cmd (fifo_head)
    );

    idq_back #(
        .NUM_LINES   (NUM_LINES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_CPUS    (NUM_CPUS),
        .TAG_WIDTH   (TAG_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!fifo_empty),
        .cmd       (fifo_head),
        .cmd_pop   (back_pop),
        .pending   (pending),
        .cpu_busy  (cpu_busy),
        .q_count   (q_count),
        .active    (back_active),
        .result    (result)
    );

    assign busy      = front_valid || !fifo_empty || back_active || result.valid;
    assign cfg_ready = 1'b1;
    assign out_valid = result.valid;
    assign kind      = result.kind;
    assign out_cpu   = result.cpu;
    assign out_irq   = result.line;
    assign out_tag   = result.tag;
    assign last      = result.last;

    `IDQ_ASSERT_NOW(a_cmd_queue_free, front_valid, fifo_empty, "command queue not free")
    `IDQ_ASSERT_NEXT(a_chain_continues, out_valid && !last, busy && !(start && !busy), "chain ended early")
    `IDQ_ASSERT_NOW(a_resume_payload, out_valid && kind == KIND_RESUME, out_irq == '0 && out_tag == '0 && last, "bad resume result")

endmodule

`default_nettype wire

### design/idq_front.sv
// Front end: configuration registers, request accept and classification.
`default_nettype none

module idq_front #(
    parameter int NUM_LINES   = idq_pkg::DEF_NUM_LINES,
    parameter int QUEUE_DEPTH = idq_pkg::DEF_QUEUE_DEPTH,
    parameter int NUM_CPUS    = idq_pkg::DEF_NUM_CPUS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic                                 func,
    input  logic                                 cpu,
    input  logic [idq_pkg::IRQ_W-1:0]            irq,
    input  logic                                 immediate,
    input  logic [idq_pkg::TAG_W-1:0]            tag,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_index,
    input  logic [idq_pkg::MASK_W-1:0]           cfg_data,
    input  logic [((NUM_LINES < 32) ? NUM_LINES : 32)-1:0] pending,
    input  logic [idq_pkg::CPU_SLOTS-1:0]        cpu_busy,
    input  logic [idq_pkg::CPU_SLOTS-1:0][$clog2(QUEUE_DEPTH+1)-1:0] q_count,
    output logic                                 cmd_valid,
    output idq_pkg::cmd_t                        cmd
);
    import idq_pkg::*;

    localparam int EFF_LINES = (NUM_LINES < 32) ? NUM_LINES : 32;
    localparam int LW        = $clog2(EFF_LINES);

    logic [MASK_W-1:0]  irq_mask_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               cmd_valid_reg;
    cmd_t               cmd_reg;

    logic       accept;
    logic       cpu_ok;
    logic       line_ok;
    logic       pend_hit;
    logic       full;
    logic       take;
    logic [1:0] op;

    assign accept   = start && !busy;
    assign cpu_ok   = 32'(cpu) < NUM_CPUS;
    assign line_ok  = 32'(irq) < NUM_LINES;
    assign pend_hit = pending[irq[LW-1:0]];
    assign full     = (32'(q_count[cpu]) >= 32'(limit_reg))
                   || (32'(q_count[cpu]) >= QUEUE_DEPTH);

    always_comb
    begin
        take = 1'b0;
        op   = OP_DELIVER;
        if (cpu_ok)
        begin
            if (func)
            begin
                take = cpu_busy[cpu];
                op   = OP_COMPLETE;
            end
            else if (line_ok && !irq_mask_reg[irq] && !pend_hit)
            begin
                if (!cpu_busy[cpu])
                begin
                    take = 1'b1;
                    op   = immediate ? OP_IMM_IDLE : OP_DELIVER;
                end
                else if (!full)
                begin
                    take = 1'b1;
                    op   = OP_ENQUEUE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_mask_reg  <= '0;
            limit_reg     <= LIMIT_RESET;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_IRQ_MASK:    irq_mask_reg <= cfg_data;
                    CFG_QUEUE_LIMIT: limit_reg    <= cfg_data[LIMIT_W-1:0];
                endcase
            end
            cmd_valid_reg <= accept && take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.op   <= op;
            cmd_reg.cpu  <= cpu;
            cmd_reg.line <= irq;
            cmd_reg.imm  <= immediate;
            cmd_reg.tag  <= tag;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

`default_nettype wire

### design/idq_cmd_fifo.sv
// Two-entry command queue between front end and dispatch engine.
`default_nettype none

module idq_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  idq_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          empty,
    output idq_pkg::cmd_t head_cmd
);
    import idq_pkg::*;

    cmd_t       slots_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    logic do_push;
    logic do_pop;

    assign do_push = push && (cnt_reg != 2'd2);
    assign do_pop  = pop && (cnt_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

    assign empty    = (cnt_reg == 2'd0);
    assign head_cmd = slots_reg[rd_ptr_reg];

endmodule

`default_nettype wire

### design/idq_back.sv
// Dispatch engine: per-CPU wait queues, pending lines and result generation.
`default_nettype none

module idq_back #(
    parameter int NUM_LINES   = idq_pkg::DEF_NUM_LINES,
    parameter int QUEUE_DEPTH = idq_pkg::DEF_QUEUE_DEPTH,
    parameter int NUM_CPUS    = idq_pkg::DEF_NUM_CPUS,
    parameter int TAG_WIDTH   = idq_pkg::DEF_TAG_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    input  idq_pkg::cmd_t                        cmd,
    output logic                                 cmd_pop,
    output logic [((NUM_LINES < 32) ? NUM_LINES : 32)-1:0] pending,
    output logic [idq_pkg::CPU_SLOTS-1:0]        cpu_busy,
    output logic [idq_pkg::CPU_SLOTS-1:0][$clog2(QUEUE_DEPTH+1)-1:0] q_count,
    output logic                                 active,
    output idq_pkg::result_t                     result
);
    import idq_pkg::*;

    localparam int EFF_LINES = (NUM_LINES < 32) ? NUM_LINES : 32;
    localparam int LW        = $clog2(EFF_LINES);
    localparam int EFF_CPUS  = (NUM_CPUS < CPU_SLOTS) ? NUM_CPUS : CPU_SLOTS;
    localparam int SW        = (TAG_WIDTH < TAG_W) ? TAG_WIDTH : TAG_W;
    localparam int QW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNW       = $clog2(QUEUE_DEPTH + 1);
    localparam int MD        = EFF_CPUS * QUEUE_DEPTH;
    localparam int AW        = (MD > 1) ? $clog2(MD) : 1;
    localparam int EW        = LW + 1 + SW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADV  = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;

    logic [EW-1:0] wait_mem [MD];

    logic [1:0]                          state_reg, state_next;
    logic                                sel_cpu_reg, sel_cpu_next;
    logic [EFF_LINES-1:0]                pending_reg, pending_next;
    logic [CPU_SLOTS-1:0]                busy_reg, busy_next;
    logic [CPU_SLOTS-1:0][LW-1:0]        cur_line_reg, cur_line_next;
    logic [CPU_SLOTS-1:0][QW-1:0]        head_reg, head_next;
    logic [CPU_SLOTS-1:0][CNW-1:0]       count_reg, count_next;
    result_t                             res_reg, res_next;
    logic [EW-1:0]                       rd_data_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic [LW-1:0] cmd_line;
    logic [SW-1:0] cmd_tag;
    logic [LW-1:0] ent_line;
    logic          ent_imm;
    logic [SW-1:0] ent_tag;
    logic [QW:0]   slot_sum;
    logic [QW-1:0] slot;

    assign cmd_line = cmd.line[LW-1:0];
    assign cmd_tag  = cmd.tag[SW-1:0];
    assign ent_line = rd_data_reg[EW-1 -: LW];
    assign ent_imm  = rd_data_reg[SW];
    assign ent_tag  = rd_data_reg[SW-1:0];
    assign slot_sum = {1'b0, head_reg[cmd.cpu]} + (QW+1)'(count_reg[cmd.cpu]);
    assign slot     = (slot_sum >= (QW+1)'(QUEUE_DEPTH))
                    ? QW'(slot_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(slot_sum);

    always_comb
    begin
        state_next    = state_reg;
        sel_cpu_next  = sel_cpu_reg;
        pending_next  = pending_reg;
        busy_next     = busy_reg;
        cur_line_next = cur_line_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        res_next      = '0;
        cmd_pop       = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = AW'(32'(cmd.cpu) * QUEUE_DEPTH + 32'(slot));
        wr_data       = {cmd_line, cmd.imm, cmd_tag};
        rd_en         = 1'b0;
        rd_addr       = AW'(32'(sel_cpu_reg) * QUEUE_DEPTH + 32'(head_reg[sel_cpu_reg]));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop      = 1'b1;
                    sel_cpu_next = cmd.cpu;
                    unique case (cmd.op)
                        OP_DELIVER:
                        begin
                            busy_next[cmd.cpu]     = 1'b1;
                            cur_line_next[cmd.cpu] = cmd_line;
                            pending_next[cmd_line] = 1'b1;
                            res_next.valid = 1'b1;
                            res_next.kind  = KIND_DELIVER;
                            res_next.cpu   = cmd.cpu;
                            res_next.line  = IRQ_W'(cmd_line);
                            res_next.tag   = TAG_W'(cmd_tag);
                            res_next.last  = 1'b1;
                        end
                        OP_IMM_IDLE:
                        begin
                            res_next.valid = 1'b1;
                            res_next.kind  = KIND_CALLBACK;
                            res_next.cpu   = cmd.cpu;
                            res_next.line  = IRQ_W'(cmd_line);
                            res_next.tag   = TAG_W'(cmd_tag);
                            res_next.last  = 1'b0;
                            state_next     = ST_ADV;
                        end
                        OP_ENQUEUE:
                        begin
                            wr_en = 1'b1;
                            count_next[cmd.cpu]    = count_reg[cmd.cpu] + CNW'(1);
                            pending_next[cmd_line] = 1'b1;
                        end
                        OP_COMPLETE:
                        begin
                            pending_next[cur_line_reg[cmd.cpu]] = 1'b0;
                            state_next = ST_ADV;
                        end
                    endcase
                end
            end
            ST_ADV:
            begin
                if (count_reg[sel_cpu_reg] == '0)
                begin
                    busy_next[sel_cpu_reg]     = 1'b0;
                    cur_line_next[sel_cpu_reg] = '0;
                    res_next.valid = 1'b1;
                    res_next.kind  = KIND_RESUME;
                    res_next.cpu   = sel_cpu_reg;
                    res_next.last  = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                head_next[sel_cpu_reg] = (head_reg[sel_cpu_reg] == QW'(QUEUE_DEPTH - 1))
                                       ? '0 : head_reg[sel_cpu_reg] + QW'(1);
                count_next[sel_cpu_reg] = count_reg[sel_cpu_reg] - CNW'(1);
                res_next.valid = 1'b1;
                res_next.cpu   = sel_cpu_reg;
                res_next.line  = IRQ_W'(ent_line);
                res_next.tag   = TAG_W'(ent_tag);
                if (ent_imm)
                begin
                    pending_next[ent_line] = 1'b0;
                    res_next.kind  = KIND_CALLBACK;
                    res_next.last  = 1'b0;
                    state_next     = ST_ADV;
                end
                else
                begin
                    busy_next[sel_cpu_reg]     = 1'b1;
                    cur_line_next[sel_cpu_reg] = ent_line;
                    res_next.kind  = KIND_DELIVER;
                    res_next.last  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            sel_cpu_reg  <= 1'b0;
            pending_reg  <= '0;
            busy_reg     <= '0;
            cur_line_reg <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            sel_cpu_reg  <= sel_cpu_next;
            pending_reg  <= pending_next;
            busy_reg     <= busy_next;
            cur_line_reg <= cur_line_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            res_reg      <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            wait_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= wait_mem[rd_addr];
    end

    assign pending  = pending_reg;
    assign cpu_busy = busy_reg;
    assign q_count  = count_reg;
    assign active   = (state_reg != ST_IDLE);
    assign result   = res_reg;

endmodule

`default_nettype wire

### tb/interrupt_dispatch_queue_test.sv
// Testbench for the per-CPU interrupt dispatch queue: directed and random requests checked by a predictor.
module interrupt_dispatch_queue_test;
    import idq_pkg::*;

    localparam logic FUNC_RAISE = 1'b0;
    localparam logic FUNC_DONE  = 1'b1;
    localparam int   DRAIN_WAIT = 16;

    typedef struct packed {
        logic             func;
        logic             cpu;
        logic [IRQ_W-1:0] irq;
        logic             imm;
        logic [TAG_W-1:0] tag;
    } request_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              cpu;
        logic [IRQ_W-1:0]  irq;
        logic [TAG_W-1:0]  tag;
        logic              last;
    } action_t;

    typedef struct packed {
        logic             imm;
        logic [IRQ_W-1:0] irq;
        logic [TAG_W-1:0] tag;
    } slot_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic func = 1'b0;
    logic cpu = 1'b0;
    logic [IRQ_W-1:0] irq = '0;
    logic immediate = 1'b0;
    logic [TAG_W-1:0] tag = '0;
    logic cfg_valid = 1'b0;
    logic cfg_index = 1'b0;
    logic [MASK_W-1:0] cfg_data = '0;
    logic busy;
    logic cfg_ready;
    logic out_valid;
    logic [KIND_W-1:0] kind;
    logic out_cpu;
    logic [IRQ_W-1:0] out_irq;
    logic [TAG_W-1:0] out_tag;
    logic last;

    interrupt_dispatch_queue dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .cpu(cpu),
        .irq(irq),
        .immediate(immediate),
        .tag(tag),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .out_valid(out_valid),
        .kind(kind),
        .out_cpu(out_cpu),
        .out_irq(out_irq),
        .out_tag(out_tag),
        .last(last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [MASK_W-1:0]  mask_reg = '0;
    logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;
    logic [31:0]        pend_lines = '0;
    slot_t              slot_mem [CPU_SLOTS][DEF_QUEUE_DEPTH];
    logic [2:0]         q_head [CPU_SLOTS] = '{default: '0};
    logic [3:0]         q_count [CPU_SLOTS] = '{default: '0};
    logic               running [CPU_SLOTS] = '{default: 1'b0};
    logic [IRQ_W-1:0]   cur_line [CPU_SLOTS] = '{default: '0};

    request_t request_q[$];
    action_t  dispatch_q[$];
    action_t  new_actions[$];
    int       issued = 0;
    int       accepted = 0;
    int       mismatches = 0;
    int       gap_pct = 0;

    task automatic add_action(input logic [KIND_W-1:0] k, input logic c,
                              input logic [IRQ_W-1:0] l, input logic [TAG_W-1:0] t);
        action_t a;
        a.kind = k;
        a.cpu = c;
        a.irq = l;
        a.tag = t;
        a.last = 1'b0;
        new_actions = {new_actions, a};
    endtask

    // pop queued entries until a CPU delivery or an empty queue
    task automatic drain_cpu(input logic c);
        slot_t e;
        bit    done;
        done = 0;
        while (!done)
        begin
            if (q_count[c] == 0)
            begin
                running[c] = 1'b0;
                cur_line[c] = '0;
                add_action(KIND_RESUME, c, '0, '0);
                done = 1;
            end
            else
            begin
                e = slot_mem[c][q_head[c]];
                q_head[c] = q_head[c] + 3'd1;
                q_count[c] = q_count[c] - 4'd1;
                if (e.imm)
                begin
                    pend_lines[e.irq] = 1'b0;
                    add_action(KIND_CALLBACK, c, e.irq, e.tag);
                end
                else
                begin
                    running[c] = 1'b1;
                    cur_line[c] = e.irq;
                    add_action(KIND_DELIVER, c, e.irq, e.tag);
                    done = 1;
                end
            end
        end
    endtask

    task automatic predict_dispatch(input request_t r);
        int    lim;
        slot_t e;
        new_actions.delete();
        if (r.func == FUNC_DONE)
        begin
            if (running[r.cpu])
            begin
                pend_lines[cur_line[r.cpu]] = 1'b0;
                drain_cpu(r.cpu);
            end
        end
        else if (!mask_reg[r.irq] && !pend_lines[r.irq])
        begin
            if (!running[r.cpu])
            begin
                if (r.imm)
                begin
                    add_action(KIND_CALLBACK, r.cpu, r.irq, r.tag);
                    drain_cpu(r.cpu);
                end
                else
                begin
                    running[r.cpu] = 1'b1;
                    cur_line[r.cpu] = r.irq;
                    pend_lines[r.irq] = 1'b1;
                    add_action(KIND_DELIVER, r.cpu, r.irq, r.tag);
                end
            end
            else
            begin
                lim = (limit_reg > DEF_QUEUE_DEPTH) ? DEF_QUEUE_DEPTH : int'(limit_reg);
                if (int'(q_count[r.cpu]) < lim)
                begin
                    e.imm = r.imm;
                    e.irq = r.irq;
                    e.tag = r.tag;
                    slot_mem[r.cpu][3'(q_head[r.cpu] + q_count[r.cpu])] = e;
                    q_count[r.cpu] = q_count[r.cpu] + 4'd1;
                    pend_lines[r.irq] = 1'b1;
                end
            end
        end
        foreach (new_actions[i])
        begin
            new_actions[i].last = (i == new_actions.size() - 1);
            dispatch_q = {dispatch_q, new_actions[i]};
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        request_t cur;
        request_t nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                cur.func = func;
                cur.cpu = cpu;
                cur.irq = irq;
                cur.imm = immediate;
                cur.tag = tag;
                predict_dispatch(cur);
                accepted++;
            end
            if (!start || !busy)
            begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= gap_pct)
                begin
                    nxt = request_q.pop_front();
                    start <= 1'b1;
                    func <= nxt.func;
                    cpu <= nxt.cpu;
                    irq <= nxt.irq;
                    immediate <= nxt.imm;
                    tag <= nxt.tag;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : check_results
        action_t want;
        if (rst_n && out_valid)
        begin
            if (dispatch_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind=%0d cpu=%0d irq=%0d tag=%h last=%0d",
                             kind, out_cpu, out_irq, out_tag, last);
            end
            else
            begin
                want = dispatch_q.pop_front();
                if (kind !== want.kind || out_cpu !== want.cpu || out_irq !== want.irq ||
                    out_tag !== want.tag || last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected kind=%0d cpu=%0d irq=%0d tag=%h last=%0d, got kind=%0d cpu=%0d irq=%0d tag=%h last=%0d",
                                 want.kind, want.cpu, want.irq, want.tag, want.last,
                                 kind, out_cpu, out_irq, out_tag, last);
                end
            end
        end
    end

    task automatic push_req(input logic f, input logic c, input logic [IRQ_W-1:0] l,
                            input logic im, input logic [TAG_W-1:0] t);
        request_t r;
        r.func = f;
        r.cpu = c;
        r.irq = l;
        r.imm = im;
        r.tag = t;
        request_q = {request_q, r};
        issued++;
    endtask

    task automatic wait_idle();
        while (accepted != issued || dispatch_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [MASK_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_IRQ_MASK)
            mask_reg = val;
        else
            limit_reg = val[LIMIT_W-1:0];
    endtask

    // bursts: raises on one CPU followed by completions, with some noise
    task automatic push_random(input int count);
        int   n;
        logic c;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                push_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                         16'($urandom));
                n++;
            end
            else
            begin
                c = 1'($urandom_range(0, 1));
                repeat ($urandom_range(1, 6))
                begin
                    push_req(FUNC_RAISE, c, 5'($urandom_range(0, 31)),
                             $urandom_range(0, 99) < 40, 16'($urandom));
                    n++;
                end
                repeat ($urandom_range(1, 4))
                begin
                    push_req(FUNC_DONE, c, 5'($urandom_range(0, 31)),
                             1'($urandom_range(0, 1)), 16'($urandom));
                    n++;
                end
            end
        end
    endtask

    initial
    begin
        #(8 * 400000);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: delivery, pending drop, queued chain, idle completion
        push_req(FUNC_RAISE, 1'b0, 5'd0, 1'b0, 16'h0000);
        push_req(FUNC_RAISE, 1'b0, 5'd0, 1'b0, 16'h1111);
        push_req(FUNC_RAISE, 1'b0, 5'd31, 1'b1, 16'hffff);
        push_req(FUNC_RAISE, 1'b0, 5'd5, 1'b0, 16'h1234);
        push_req(FUNC_RAISE, 1'b0, 5'd6, 1'b1, 16'h8001);
        push_req(FUNC_DONE, 1'b0, 5'd0, 1'b0, 16'h0000);
        push_req(FUNC_DONE, 1'b0, 5'd0, 1'b0, 16'h0000);
        push_req(FUNC_DONE, 1'b0, 5'd0, 1'b0, 16'h0000);
        // immediate on an idle CPU
        push_req(FUNC_RAISE, 1'b1, 5'd7, 1'b1, 16'hbeef);
        // full queue, overflow drop, longest chain
        push_req(FUNC_RAISE, 1'b1, 5'd8, 1'b0, 16'h0808);
        for (int i = 9; i <= 16; i++)
            push_req(FUNC_RAISE, 1'b1, 5'(i), 1'b1, 16'(i * 16'h0101));
        push_req(FUNC_RAISE, 1'b1, 5'd17, 1'b0, 16'h1717);
        push_req(FUNC_DONE, 1'b1, 5'd31, 1'b1, 16'hffff);
        wait_idle();

        write_reg(CFG_IRQ_MASK, 32'hffffffff);
        push_req(FUNC_RAISE, 1'b0, 5'd3, 1'b0, 16'h0003);
        push_req(FUNC_RAISE, 1'b1, 5'd31, 1'b1, 16'h001f);
        wait_idle();

        write_reg(CFG_IRQ_MASK, 32'h80000001);
        write_reg(CFG_QUEUE_LIMIT, 32'd0);
        push_req(FUNC_RAISE, 1'b0, 5'd2, 1'b0, 16'h0002);
        push_req(FUNC_RAISE, 1'b0, 5'd4, 1'b1, 16'h0004);
        push_req(FUNC_DONE, 1'b0, 5'd0, 1'b0, 16'h0000);
        wait_idle();

        write_reg(CFG_IRQ_MASK, 32'h0);
        write_reg(CFG_QUEUE_LIMIT, 32'd8);
        gap_pct = 0;
        push_random(100);
        wait_idle();

        write_reg(CFG_IRQ_MASK, $urandom & $urandom & $urandom);
        write_reg(CFG_QUEUE_LIMIT, 32'd15);
        gap_pct = 54;
        push_random(100);
        wait_idle();

        write_reg(CFG_QUEUE_LIMIT, 32'd3);
        gap_pct = 0;
        push_random(60);
        wait_idle();

        write_reg(CFG_IRQ_MASK, $urandom & $urandom);
        write_reg(CFG_QUEUE_LIMIT, 32'd1);
        gap_pct = 11;
        push_random(70);
        wait_idle();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
